// ===== sv/abcr_pkg.sv =====
// ----------------------------------------------------------------------------
// abcr_pkg
// Shared types and constants of the audio bitcrusher: register indexes,
// fixed field widths and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package abcr_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int LEVEL_W   = 17;
	localparam int STEPS_W   = 16;
	localparam int HOLD_W    = 6;
	localparam int GAIN_W    = 16;
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 4;

	localparam logic [HOLD_W-1:0]       MAX_HOLD   = 6'd32;
	localparam logic signed [32:0]      HALF_SCALE = 33'sd16384;
	localparam logic [SAMPLE_W-1:0]     POS_MAX    = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0]     NEG_MIN    = 16'h8000;
	localparam logic [SAMPLE_W-1:0]     NEG_LIMIT  = 16'h8000;

	localparam logic [STEPS_W-1:0] QUANT_STEPS_RST = 16'd7;
	localparam logic [HOLD_W-1:0]  HOLD_FACTOR_RST = 6'd8;
	localparam logic [GAIN_W-1:0]  OUTPUT_GAIN_RST = 16'd16384;

	typedef enum logic [1:0] {
		REG_QUANT_STEPS = 2'd0,
		REG_HOLD_FACTOR = 2'd1,
		REG_OUTPUT_GAIN = 2'd2
	} abcr_reg_t;

	typedef struct packed {
		logic capture;
		logic level;
		logic gain;
		logic scale;
		logic check;
		logic div_step;
		logic load_out;
	} abcr_cmd_t;

endpackage

// ===== sv/abcr_dp.sv =====
// ----------------------------------------------------------------------------
// abcr_dp
// Datapath: quantizer multiply, hold counter and held level, gain multiply,
// 32767 scaling, a radix-2 restoring divider by the step count and saturation.
// ----------------------------------------------------------------------------
module abcr_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  abcr_pkg::abcr_cmd_t                  cmd,
	input  logic signed [abcr_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [abcr_pkg::STEPS_W-1:0]         quant_steps,
	input  logic [abcr_pkg::HOLD_W-1:0]          hold_factor,
	input  logic [abcr_pkg::GAIN_W-1:0]          output_gain,
	output logic signed [abcr_pkg::SAMPLE_W-1:0] sample_out
);

	logic signed [32:0]                   prod_q;
	logic signed [32:0]                   round_sum;
	logic signed [abcr_pkg::LEVEL_W-1:0]  level;
	logic [abcr_pkg::HOLD_W-1:0]          factor;
	logic [abcr_pkg::HOLD_W-1:0]          cnt_inc;
	logic [abcr_pkg::HOLD_W-1:0]          hold_count_q;
	logic signed [abcr_pkg::LEVEL_W-1:0]  held_level_q;
	logic [abcr_pkg::LEVEL_W-1:0]         mag;
	logic                                 neg_q;
	logic [31:0]                          gprod_q;
	logic [46:0]                          scaled;
	logic [32:0]                          num_q;
	logic [16:0]                          rem_q;
	logic [16:0]                          trial;
	logic [16:0]                          steps_ext;
	logic [15:0]                          low_q;
	logic [15:0]                          quo_q;
	logic                                 sat_q;
	logic [16:0]                          quo_neg;
	logic [abcr_pkg::SAMPLE_W-1:0]        result;
	logic [abcr_pkg::SAMPLE_W-1:0]        sample_out_q;

	// floor((s*steps + 16384) / 32768)
	assign round_sum = prod_q + abcr_pkg::HALF_SCALE;
	assign level     = round_sum[31:15];

	assign factor  = (hold_factor > abcr_pkg::MAX_HOLD) ? abcr_pkg::MAX_HOLD : hold_factor;
	assign cnt_inc = hold_count_q + 6'd1;

	assign mag       = held_level_q[16] ? (~held_level_q + 17'd1) : held_level_q;
	assign scaled    = {gprod_q, 15'b0} - {15'b0, gprod_q};
	assign steps_ext = {1'b0, quant_steps};
	assign trial     = {rem_q[15:0], low_q[15]};
	assign quo_neg   = 17'd0 - {1'b0, quo_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			prod_q <= $signed(sample_in) * $signed({1'b0, quant_steps});
		end
	end

	// held level and hold counter are architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_level_q <= '0;
			hold_count_q <= '0;
		end else if (cmd.level) begin
			if (cnt_inc >= factor) begin
				held_level_q <= level;
				hold_count_q <= '0;
			end else begin
				hold_count_q <= cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gain) begin
			neg_q   <= held_level_q[16];
			gprod_q <= mag[15:0] * output_gain;
		end
		if (cmd.scale) begin
			// times 32767, then drop the 2^14 of the unity gain
			num_q <= scaled[46:14];
		end
		if (cmd.check) begin
			rem_q <= num_q[32:16];
			low_q <= num_q[15:0];
			quo_q <= '0;
			sat_q <= (num_q[32:16] >= steps_ext);
		end else if (cmd.div_step) begin
			low_q <= {low_q[14:0], 1'b0};
			if (trial >= steps_ext) begin
				rem_q <= trial - steps_ext;
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			sample_out_q <= result;
		end
	end

	always_comb begin
		if (quant_steps == '0) begin
			result = '0;
		end else if (!neg_q) begin
			result = (sat_q || quo_q[15]) ? abcr_pkg::POS_MAX : quo_q;
		end else if (sat_q || (quo_q > abcr_pkg::NEG_LIMIT)) begin
			result = abcr_pkg::NEG_MIN;
		end else begin
			result = quo_neg[15:0];
		end
	end

	assign sample_out = sample_out_q;

endmodule

// ===== sv/abcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// abcr_ctrl
// Controller: sequences one sample through the datapath and owns the input
// ready and the output valid.
// ----------------------------------------------------------------------------
module abcr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output abcr_pkg::abcr_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LEVEL = 7'b0000010,
		ST_GAIN  = 7'b0000100,
		ST_SCALE = 7'b0001000,
		ST_CHECK = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t                           state_q;
	state_t                           state_d;
	logic [abcr_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic                             out_valid_q;
	logic                             out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				cmd.level = 1'b1;
				state_d   = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// wait here while the previous result is still unclaimed
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.check) begin
				div_cnt_q <= abcr_pkg::DIV_CNT_W'(abcr_pkg::DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/audio_bitcrusher.sv =====
// ----------------------------------------------------------------------------
// audio_bitcrusher
// Bit-depth and sample-rate reduction: quantize, hold, apply gain, saturate.
// ----------------------------------------------------------------------------
// sequence: the sample passes LEVEL, GAIN, SCALE, CHECK, DIV and FIN; out_valid rises once FIN loads it
// a new sample is accepted only in IDLE, after the 16 divider steps and the load in FIN
// the next sample is taken while the last result waits in the output register
// reset: held level and hold count clear, registers return to 7 / 8 / 16384
module audio_bitcrusher (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [abcr_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [abcr_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_idx,
	input  logic [abcr_pkg::STEPS_W-1:0]         cfg_data
);

	logic [abcr_pkg::STEPS_W-1:0] quant_steps_q;
	logic [abcr_pkg::HOLD_W-1:0]  hold_factor_q;
	logic [abcr_pkg::GAIN_W-1:0]  output_gain_q;
	abcr_pkg::abcr_cmd_t          cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_steps_q <= abcr_pkg::QUANT_STEPS_RST;
			hold_factor_q <= abcr_pkg::HOLD_FACTOR_RST;
			output_gain_q <= abcr_pkg::OUTPUT_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				abcr_pkg::REG_QUANT_STEPS: quant_steps_q <= cfg_data;
				abcr_pkg::REG_HOLD_FACTOR: hold_factor_q <= cfg_data[abcr_pkg::HOLD_W-1:0];
				abcr_pkg::REG_OUTPUT_GAIN: output_gain_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	abcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	abcr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sample_in   (sample_in),
		.quant_steps (quant_steps_q),
		.hold_factor (hold_factor_q),
		.output_gain (output_gain_q),
		.sample_out  (sample_out)
	);

	// one sample in flight: no new transaction right after one is taken
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	// a result only appears after the controller loaded it
	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load_out))
		else $error("out_valid rose without a load");

	// zero steps at load time gives silence; checked against the current step count
	a_zero_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (quant_steps_q == '0)) |-> (sample_out == '0))
		else $error("nonzero output with zero steps");

endmodule
